// ===== rtl/core/rth_pkg.sv =====
// Shared types and constants for the 8-bit RGB to HSV converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package rth_pkg;

  // Scale factors and hue base points on the 0..255 circle
  localparam logic [7:0] HsvFull  = 8'd255;
  localparam logic [7:0] HsvSixth = 8'd43;
  localparam logic [7:0] HsvGreen = 8'd85;
  localparam logic [7:0] HsvBlue  = 8'd171;

  // Divider geometry: 16-bit dividend, 8-bit divisor, one quotient bit per stage
  localparam int unsigned ChanW     = 8;
  localparam int unsigned NumW      = 2 * ChanW;
  localparam int unsigned QuoW      = ChanW;
  localparam int unsigned DivStages = QuoW;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [NumW-1:0]  num_t;

  // Data that rides alongside the divider stages
  typedef struct packed {
    chan_t hi;     // largest channel
    chan_t base;   // hue base point
    logic  neg;    // hue offset is negative
    logic  grey;   // spread is zero (black included)
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/core/rth_div_pipe.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on rth_pkg. Quotient must fit in QuoW bits (num < den * 2**QuoW).
`default_nettype none

module rth_div_pipe (
  input  wire                 clk_i,
  input  wire                 en_i,
  input  wire  rth_pkg::num_t  num_i,
  input  wire  rth_pkg::chan_t den_i,
  output logic [rth_pkg::QuoW-1:0] quo_o
);
  import rth_pkg::*;

  num_t           work_q [DivStages];
  chan_t          den_q  [DivStages];
  logic [QuoW-1:0] quo_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    num_t            work_in;
    chan_t           den_in;
    logic [QuoW-1:0] quo_in;
    logic [ChanW:0]  trial;
    logic            fit;
    chan_t           rem_d;

    if (s == 0) begin : g_first
      assign work_in = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
    end else begin : g_next
      assign work_in = work_q[s-1];
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
    end

    // Bring down the next dividend bit and try the subtract
    assign trial = work_in[NumW-1:NumW-ChanW-1];
    assign fit   = trial >= {1'b0, den_in};

    always_comb begin
      if (fit) begin
        rem_d = ChanW'(trial - {1'b0, den_in});
      end else begin
        rem_d = trial[ChanW-1:0];
      end
    end

    // Advance partial remainder, divisor and quotient bits
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q[s] <= {rem_d, work_in[NumW-ChanW-2:0], 1'b0};
        den_q[s]  <= den_in;
        quo_q[s]  <= {quo_in[QuoW-2:0], fit};
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];

endmodule

`default_nettype wire

// ===== rtl/core/rgb_to_hsv_8bit.sv =====
// Stages from request acceptance to result: max/min, dividend, eight divider
// stages, output. Throughput: one pixel per cycle while the output is not
// stalled; the two divisions run in parallel bit-per-stage pipelines.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload is not reset.
`default_nettype none

module rgb_to_hsv_8bit (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire  rth_pkg::chan_t red_i,
  input  wire  rth_pkg::chan_t green_i,
  input  wire  rth_pkg::chan_t blue_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output rth_pkg::chan_t       hue_o,
  output rth_pkg::chan_t       saturation_o,
  output rth_pkg::chan_t       brightness_o
);
  import rth_pkg::*;

  logic en;

  // Stage 1 registers: extremes, base point and offset magnitude
  logic  s1_vld_q;
  chan_t s1_hi_q, s1_spread_q, s1_base_q, s1_mag_q;
  logic  s1_neg_q;

  // Stage 2 registers: dividends and divisors
  logic  s2_vld_q;
  num_t  s2_sat_num_q, s2_hue_num_q;
  chan_t s2_spread_q;
  side_t s2_side_q;

  // Side line through the divider
  logic  div_vld_q  [DivStages];
  side_t div_side_q [DivStages];

  logic [QuoW-1:0] sat_quo, hue_quo;

  // Output register
  logic  out_vld_q;
  chan_t hue_q, sat_q, bri_q;

  // Advance the whole pipeline unless the output holds an untaken result
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // Max, min and hue base selection (red wins ties, then green)
  chan_t    hi_d, lo_d, base_d, x_d, y_d, mag_d;
  logic [ChanW:0] diff_d;
  always_comb begin
    hi_d = (red_i > green_i) ? red_i : green_i;
    if (blue_i > hi_d) begin
      hi_d = blue_i;
    end
    lo_d = (red_i < green_i) ? red_i : green_i;
    if (blue_i < lo_d) begin
      lo_d = blue_i;
    end
    if (hi_d == red_i) begin
      base_d = '0;
      x_d    = green_i;
      y_d    = blue_i;
    end else if (hi_d == green_i) begin
      base_d = HsvGreen;
      x_d    = blue_i;
      y_d    = red_i;
    end else begin
      base_d = HsvBlue;
      x_d    = red_i;
      y_d    = green_i;
    end
    diff_d = {1'b0, x_d} - {1'b0, y_d};
    mag_d  = diff_d[ChanW] ? ChanW'(-diff_d) : diff_d[ChanW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_hi_q     <= hi_d;
      s1_spread_q <= hi_d - lo_d;
      s1_base_q   <= base_d;
      s1_mag_q    <= mag_d;
      s1_neg_q    <= diff_d[ChanW];
    end
  end

  // Form the scaled dividends: 255 * spread and 43 * |diff|
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_sat_num_q   <= NumW'(s1_spread_q) * NumW'(HsvFull);
      s2_hue_num_q   <= NumW'(s1_mag_q) * NumW'(HsvSixth);
      s2_spread_q    <= s1_spread_q;
      s2_side_q.hi   <= s1_hi_q;
      s2_side_q.base <= s1_base_q;
      s2_side_q.neg  <= s1_neg_q;
      s2_side_q.grey <= (s1_spread_q == '0);
    end
  end

  // Saturation divides by value, hue offset by spread
  rth_div_pipe u_sat_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s2_sat_num_q),
    .den_i (s2_side_q.hi),
    .quo_o (sat_quo)
  );

  rth_div_pipe u_hue_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s2_hue_num_q),
    .den_i (s2_spread_q),
    .quo_o (hue_quo)
  );

  // Carry valid and side data alongside the divider stages
  for (genvar s = 0; s < DivStages; s++) begin : g_side
    logic  vld_in;
    side_t side_in;
    if (s == 0) begin : g_first
      assign vld_in  = s2_vld_q;
      assign side_in = s2_side_q;
    end else begin : g_next
      assign vld_in  = div_vld_q[s-1];
      assign side_in = div_side_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_vld_q[s] <= 1'b0;
      end else if (en) begin
        div_vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_side_q[s] <= side_in;
      end
    end
  end

  // Apply the signed offset to the base, force hue and saturation of grey pixels to zero
  side_t side_last;
  chan_t hue_d, sat_d;
  assign side_last = div_side_q[DivStages-1];
  always_comb begin
    if (side_last.grey) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      hue_d = side_last.neg ? side_last.base - ChanW'(hue_quo)
                            : side_last.base + ChanW'(hue_quo);
      sat_d = ChanW'(sat_quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= div_vld_q[DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      bri_q <= side_last.hi;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bri_q;

endmodule

`default_nettype wire

// ===== rtl/core/rth_checker.sv =====
// Port-level checks for the RGB to HSV converter, bound to the top level.
// Depends on rth_pkg and rgb_to_hsv_8bit.
`default_nettype none

module rth_checker (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  in_valid_i,
  input wire                  in_ready_o,
  input wire                  out_valid_o,
  input wire                  out_ready_i,
  input wire  rth_pkg::chan_t hue_o,
  input wire  rth_pkg::chan_t saturation_o,
  input wire  rth_pkg::chan_t brightness_o
);
  import rth_pkg::*;

  // Hold a result until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hue_o)
      && $stable(saturation_o) && $stable(brightness_o))
    else $error("result dropped or changed while stalled");

  // Only a stalled result may block new requests
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request refused without an output stall");

  // Black pixel gives zero hue and saturation
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && brightness_o == '0 |-> hue_o == '0 && saturation_o == '0)
    else $error("black pixel with non-zero hue or saturation");

  // Zero saturation means a grey pixel, whose hue is zero
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturation_o == '0 |-> hue_o == '0)
    else $error("grey pixel with non-zero hue");

endmodule

bind rgb_to_hsv_8bit rth_checker u_rth_checker (.*);

`default_nettype wire
